FILE: rtl/tlvd_pkg.sv
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared types and constants for the type-length-value record deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

  // width of the kept record length (8..32)
  localparam int unsigned LENGTH_BITS = 32;

  // largest length that can be kept, longer headers saturate to this
  localparam logic [31:0] LEN_MAX = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  // header byte positions
  localparam logic [2:0] HDR_TYPE_HI = 3'd0;
  localparam logic [2:0] HDR_TYPE_LO = 3'd1;
  localparam logic [2:0] HDR_LEN_B3  = 3'd2;
  localparam logic [2:0] HDR_LEN_B2  = 3'd3;
  localparam logic [2:0] HDR_LEN_B1  = 3'd4;
  localparam logic [2:0] HDR_LEN_B0  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } tlv_item_t;

  typedef struct packed {
    logic [15:0] rec_type;
    logic [31:0] rec_length;
    logic [7:0]  value_byte;
    logic        byte_valid;
    logic        record_last;
  } tlv_result_t;

endpackage

FILE: rtl/tlvd_in_stage.sv
// ----------------------------------------------------------------------------
// tlvd_in_stage
// Input register: holds one stream byte until the parser consumes it.
// ----------------------------------------------------------------------------
module tlvd_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tlvd_pkg::tlv_item_t  in_item,
  input  logic                 consume,
  output logic                 s1_valid,
  output tlvd_pkg::tlv_item_t  s1_item
);
  import tlvd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  tlv_item_t item_r;

  assign in_ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (consume) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: rtl/tlvd_parser.sv
// ----------------------------------------------------------------------------
// tlvd_parser
// Record walker: collects the 6-byte header, then counts down value bytes.
// ----------------------------------------------------------------------------
module tlvd_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlvd_pkg::tlv_item_t    item,
  input  logic                   step,
  output logic                   res_valid,
  output tlvd_pkg::tlv_result_t  res
);
  import tlvd_pkg::*;

  logic                   in_value_phase_r;
  logic                   in_value_phase_nxt;
  logic [2:0]             header_count_r;
  logic [2:0]             header_count_nxt;
  logic [15:0]            type_hold_r;
  logic [15:0]            type_hold_nxt;
  logic [31:0]            length_hold_r;
  logic [31:0]            length_hold_nxt;
  logic [LENGTH_BITS-1:0] bytes_left_r;
  logic [LENGTH_BITS-1:0] bytes_left_nxt;

  logic                   phase;
  logic [2:0]             hc;
  logic [31:0]            len_cand;
  logic                   last;

  always_comb begin
    // restart drops any partial header or record
    phase    = in_value_phase_r && !item.restart;
    hc       = item.restart ? HDR_TYPE_HI : header_count_r;
    if (hc > HDR_LEN_B0) begin
      hc = HDR_TYPE_HI;
    end
    len_cand = {length_hold_r[23:0], item.data_byte};

    in_value_phase_nxt = phase;
    header_count_nxt   = hc;
    type_hold_nxt      = type_hold_r;
    length_hold_nxt    = length_hold_r;
    bytes_left_nxt     = bytes_left_r;
    last               = 1'b0;
    res_valid          = 1'b0;
    res                = '0;

    if (phase) begin
      bytes_left_nxt = bytes_left_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
      last           = (bytes_left_nxt == '0);
      res_valid      = 1'b1;
      res.rec_type    = type_hold_r;
      res.rec_length  = length_hold_r;
      res.value_byte  = item.data_byte;
      res.byte_valid  = 1'b1;
      res.record_last = last;
      in_value_phase_nxt = !last;
    end else begin
      case (hc)
        HDR_TYPE_HI: type_hold_nxt   = {item.data_byte, 8'h00};
        HDR_TYPE_LO: type_hold_nxt   = {type_hold_r[15:8], item.data_byte};
        HDR_LEN_B3:  length_hold_nxt = {24'h0, item.data_byte};
        default:     length_hold_nxt = len_cand;
      endcase

      if (hc != HDR_LEN_B0) begin
        header_count_nxt = hc + 3'd1;
      end else begin
        header_count_nxt = HDR_TYPE_HI;
        if (len_cand > LEN_MAX) begin
          length_hold_nxt = LEN_MAX;
        end
        if (length_hold_nxt == 32'h0) begin
          // empty record marker
          res_valid       = 1'b1;
          res.rec_type    = type_hold_r;
          res.rec_length  = 32'h0;
          res.value_byte  = 8'h00;
          res.byte_valid  = 1'b0;
          res.record_last = 1'b1;
        end else begin
          bytes_left_nxt     = length_hold_nxt[LENGTH_BITS-1:0];
          in_value_phase_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_phase_r <= 1'b0;
      header_count_r   <= HDR_TYPE_HI;
    end else if (step) begin
      in_value_phase_r <= in_value_phase_nxt;
      header_count_r   <= header_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      type_hold_r   <= type_hold_nxt;
      length_hold_r <= length_hold_nxt;
      bytes_left_r  <= bytes_left_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_hc_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_count_r <= HDR_LEN_B0)
    else $error("header count out of range");

  a_value_hc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_value_phase_r |-> (header_count_r == HDR_TYPE_HI))
    else $error("header count not cleared in value phase");

  a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
    in_value_phase_r |-> (bytes_left_r != '0))
    else $error("value phase with no bytes left");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.byte_valid) |-> (res.record_last && res.rec_length == 32'h0))
    else $error("empty record marker malformed");

  a_leave_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res.byte_valid && res.record_last) |=> !in_value_phase_r)
    else $error("value phase kept after last byte");
`endif

endmodule

FILE: rtl/tlvd_out_skid.sv
// ----------------------------------------------------------------------------
// tlvd_out_skid
// Output register with one skid entry, keeps out_ready off the input path.
// ----------------------------------------------------------------------------
module tlvd_out_skid (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  tlvd_pkg::tlv_result_t  push_data,
  output logic                   can_take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tlvd_pkg::tlv_result_t  out_data
);
  import tlvd_pkg::*;

  logic        main_valid_r;
  logic        main_valid_nxt;
  logic        skid_valid_r;
  logic        skid_valid_nxt;
  tlv_result_t main_r;
  tlv_result_t skid_r;
  logic        pop;
  logic        load_main;
  logic        load_skid;
  logic        skid_to_main;

  assign pop      = main_valid_r && out_ready;
  assign can_take = !skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_main      = 1'b0;
    load_skid      = 1'b0;
    skid_to_main   = 1'b0;
    if (skid_valid_r) begin
      if (pop) begin
        skid_to_main   = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        load_main      = 1'b1;
        main_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_to_main) begin
      main_r <= skid_r;
    end else if (load_main) begin
      main_r <= push_data;
    end
    if (load_skid) begin
      skid_r <= push_data;
    end
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

FILE: rtl/tlv_record_deframer_unit.sv
// an accepted byte is held in the input register, and its result is then registered in the output stage
// throughput: one byte per cycle, header bytes included, while results find room on the output side
// a result waits in the output register plus one skid entry, so input stalls only when both fill
// reset (rst_n low, synchronous) empties all stages and returns the parser to header sync
// ----------------------------------------------------------------------------
// tlv_record_deframer_unit
// Walks back-to-back type-length-value records and emits one result per value byte, or one marker for an empty record.
// ----------------------------------------------------------------------------
module tlv_record_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_rec_type,
  output logic [31:0] out_rec_length,
  output logic [7:0]  out_value_byte,
  output logic        out_byte_valid,
  output logic        out_record_last
);
  import tlvd_pkg::*;

  tlv_item_t   in_item;
  tlv_item_t   s1_item;
  logic        s1_valid;
  logic        consume;
  logic        res_valid;
  tlv_result_t res;
  logic        can_take;
  tlv_result_t out_data;

  assign in_item.data_byte = in_data_byte;
  assign in_item.restart   = in_restart;

  // a byte without a result never waits on the output side
  assign consume = s1_valid && (!res_valid || can_take);

  tlvd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .consume  (consume),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  tlvd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (s1_item),
    .step      (consume),
    .res_valid (res_valid),
    .res       (res)
  );

  tlvd_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (consume && res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_rec_type    = out_data.rec_type;
  assign out_rec_length  = out_data.rec_length;
  assign out_value_byte  = out_data.value_byte;
  assign out_byte_valid  = out_data.byte_valid;
  assign out_record_last = out_data.record_last;

endmodule
